/* hw/rtl/rkpf_pkg.sv */
package rkpf_pkg;

    localparam int CH_W       = 3;
    localparam int RANGE_W    = 16;
    localparam int VAR_W      = 16;
    localparam int ERR_W      = 17;
    localparam int GAIN_W     = 16;
    localparam int FLAG_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_VAR     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEASUREMENT_VAR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_FRONT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_OTHER = 2'd3;

    localparam logic [VAR_W-1:0]   PROCESS_VAR_RESET     = 16'd655;
    localparam logic [VAR_W-1:0]   MEASUREMENT_VAR_RESET = 16'd6554;
    localparam logic [RANGE_W-1:0] THRESHOLD_FRONT_RESET = 16'd4096;
    localparam logic [RANGE_W-1:0] THRESHOLD_OTHER_RESET = 16'd2048;
    localparam logic [ERR_W-1:0]   ERROR_RESET           = 17'h10000;
    localparam logic [ERR_W-1:0]   ONE_Q16               = 17'h10000;

    typedef struct packed {
        logic [CH_W-1:0]    channel;
        logic [RANGE_W-1:0] range_in;
    } sample_t;

    typedef struct packed {
        logic [CH_W-1:0]    channel_out;
        logic [RANGE_W-1:0] estimate;
        logic [FLAG_W-1:0]  near_flags;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DIV,
        ST_MUL_EST,
        ST_MUL_ERR,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic             start;
        logic [ERR_W-1:0] prior;
        logic [ERR_W:0]   den;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [GAIN_W-1:0] gain;
    } div_rsp_t;

endpackage

/* hw/rtl/rkpf_gain_div.sv */
module rkpf_gain_div
    import rkpf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int STEPS = GAIN_W + 1;
    localparam int CNT_W = $clog2(STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STEPS - 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [ERR_W:0]   rem_reg;
    logic [ERR_W:0]   den_reg;
    logic [GAIN_W:0]  quo_reg;
    logic             zero_reg;

    logic [ERR_W+1:0] trial;
    logic             fits;
    logic [ERR_W+1:0] diff;
    logic [ERR_W:0]   rem_next;

    // first step compares the integer part, later steps shift in zeros
    always_comb
    begin
        trial    = (cnt_reg == '0) ? {1'b0, rem_reg} : {rem_reg, 1'b0};
        fits     = trial >= {1'b0, den_reg};
        diff     = trial - {1'b0, den_reg};
        rem_next = fits ? diff[ERR_W:0] : trial[ERR_W:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg  <= {1'b0, req.prior};
            den_reg  <= req.den;
            zero_reg <= (req.den == '0);
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[GAIN_W-1:0], fits};
        end
    end

    always_comb
    begin
        rsp.done = done_reg;
        if (zero_reg)
            rsp.gain = '0;
        else if (quo_reg[GAIN_W])
            rsp.gain = '1;
        else
            rsp.gain = quo_reg[GAIN_W-1:0];
    end

endmodule

/* hw/rtl/range_kalman_proximity_flags.sv */
// a sample passes through read, the 17-step gain divider, gain capture, the estimate multiply,
// the error multiply and write-back before result valid (an out-of-range channel skips to the result)
// one sample in flight: sample_stall holds from acceptance until write-back, which waits on a stalled full output;
// a new sample is taken while the previous result waits in the output register
// reset: estimates read as zero, shared error 1.0, near flags clear, registers at defaults
module range_kalman_proximity_flags
    import rkpf_pkg::*;
#(
    parameter int CHANNELS = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  sample_valid,
    output logic                  sample_stall,
    input  sample_t               sample,
    output logic                  result_valid,
    input  logic                  result_stall,
    output result_t               result,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [FLAG_W-1:0] NEAR_MASK =
        (CHANNELS >= FLAG_W) ? '1 : FLAG_W'((1 << CHANNELS) - 1);

    state_t state_reg;
    state_t state_next;

    logic [VAR_W-1:0]   pv_reg;
    logic [VAR_W-1:0]   mv_reg;
    logic [RANGE_W-1:0] thr_front_reg;
    logic [RANGE_W-1:0] thr_other_reg;

    logic [RANGE_W-1:0] est_mem [CHANNELS];
    logic [RANGE_W-1:0] rd_data_reg;
    logic [CHANNELS-1:0] est_valid_reg;

    logic [ERR_W-1:0]  shared_error_reg;
    logic [FLAG_W-1:0] near_bits_reg;
    logic [FLAG_W-1:0] near_bits_next;

    sample_t            item_reg;
    logic [RANGE_W-1:0] est_reg;
    logic [RANGE_W-1:0] diff_reg;
    logic               sub_reg;
    logic [ERR_W-1:0]   prior_reg;
    logic [GAIN_W-1:0]  gain_reg;
    logic [2*RANGE_W-1:0] corr_prod_reg;
    logic [2*ERR_W-1:0]   err_prod_reg;

    logic    result_valid_reg;
    result_t result_reg;

    logic               ch_ok;
    logic [IDX_W-1:0]   item_addr;
    logic [RANGE_W-1:0] est_cur;
    logic [ERR_W:0]     prior_sum;
    logic [ERR_W-1:0]   prior_sat;
    logic [ERR_W-1:0]   inv_gain;
    logic [RANGE_W-1:0] corr;
    logic [RANGE_W-1:0] est_new;
    logic [RANGE_W-1:0] thr;
    logic               done_fire;
    logic               mem_we;
    div_req_t           div_req;
    div_rsp_t           div_rsp;

    rkpf_gain_div u_gain_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        ch_ok     = int'(item_reg.channel) < CHANNELS;
        item_addr = IDX_W'(item_reg.channel);
        est_cur   = (ch_ok && est_valid_reg[item_addr]) ? rd_data_reg : '0;
        prior_sum = {1'b0, shared_error_reg} + (ERR_W+1)'(pv_reg);
        prior_sat = prior_sum[ERR_W] ? '1 : prior_sum[ERR_W-1:0];
        inv_gain  = ONE_Q16 - {1'b0, gain_reg};
        corr      = corr_prod_reg[2*RANGE_W-1:RANGE_W];
        est_new   = sub_reg ? (est_reg - corr) : (est_reg + corr);
        thr       = (item_reg.channel == '0) ? thr_front_reg : thr_other_reg;
        near_bits_next = near_bits_reg;
        near_bits_next[item_reg.channel] = est_new < thr;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                    state_next = ST_READ;
            end
            ST_READ:
            begin
                state_next = ch_ok ? ST_DIV : ST_DONE;
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                    state_next = ST_MUL_EST;
            end
            ST_MUL_EST:
            begin
                state_next = ST_MUL_ERR;
            end
            ST_MUL_ERR:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!result_valid_reg || !result_stall)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        sample_stall  = (state_reg != ST_IDLE);
        done_fire     = (state_reg == ST_DONE) && (!result_valid_reg || !result_stall);
        mem_we        = done_fire && ch_ok;
        div_req.start = (state_reg == ST_READ) && ch_ok;
        div_req.prior = prior_sat;
        div_req.den   = {1'b0, prior_sat} + (ERR_W+1)'(mv_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg        <= PROCESS_VAR_RESET;
            mv_reg        <= MEASUREMENT_VAR_RESET;
            thr_front_reg <= THRESHOLD_FRONT_RESET;
            thr_other_reg <= THRESHOLD_OTHER_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_PROCESS_VAR:     pv_reg        <= cfg_data;
                CFG_MEASUREMENT_VAR: mv_reg        <= cfg_data;
                CFG_THRESHOLD_FRONT: thr_front_reg <= cfg_data;
                CFG_THRESHOLD_OTHER: thr_other_reg <= cfg_data;
            endcase
        end
    end

    // estimate store, one read port and one write port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            est_mem[item_addr] <= est_new;
        rd_data_reg <= est_mem[IDX_W'(sample.channel)];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            est_valid_reg    <= '0;
            shared_error_reg <= ERROR_RESET;
            near_bits_reg    <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (mem_we)
            begin
                est_valid_reg[item_addr] <= 1'b1;
                shared_error_reg <= err_prod_reg[ERR_W+GAIN_W-1:GAIN_W];
                near_bits_reg    <= near_bits_next & NEAR_MASK;
            end
            if (done_fire)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_valid && !sample_stall)
            item_reg <= sample;
        if (state_reg == ST_READ)
        begin
            est_reg   <= est_cur;
            sub_reg   <= item_reg.range_in < est_cur;
            diff_reg  <= (item_reg.range_in < est_cur) ? (est_cur - item_reg.range_in)
                                                        : (item_reg.range_in - est_cur);
            prior_reg <= prior_sat;
        end
        if ((state_reg == ST_DIV) && div_rsp.done)
            gain_reg <= div_rsp.gain;
        if (state_reg == ST_MUL_EST)
            corr_prod_reg <= gain_reg * diff_reg;
        if (state_reg == ST_MUL_ERR)
            err_prod_reg <= inv_gain * prior_reg;
        if (done_fire)
        begin
            result_reg.channel_out <= item_reg.channel;
            result_reg.estimate    <= ch_ok ? est_new : '0;
            result_reg.near_flags  <= ch_ok ? (near_bits_next & NEAR_MASK) : near_bits_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && !sample_stall) |=> sample_stall)
        else $error("sample taken while another transaction is in flight");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide state");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised without a finished update");

    a_flags_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (near_bits_reg & ~NEAR_MASK) == '0)
        else $error("near flag set for a channel that does not exist");

endmodule

/* tb/sv/tb_range_kalman_proximity_flags.sv */
`timescale 1ns / 1ps

module tb_range_kalman_proximity_flags;
    import rkpf_pkg::*;

    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 215;
    localparam int HOLD_CYCLES   = 400;
    localparam int HOLD_AFTER    = 300;
    localparam int QUIET_LIMIT   = 4000;
    localparam int DRAIN_CYCLES  = 40;
    localparam int REPORT_MAX    = 10;

    class kalman_scoreboard;
        logic [VAR_W-1:0]   process_var;
        logic [VAR_W-1:0]   meas_var;
        logic [RANGE_W-1:0] thr_front;
        logic [RANGE_W-1:0] thr_other;
        logic [RANGE_W-1:0] est_mem [8];
        logic [ERR_W-1:0]   error_var;
        logic [FLAG_W-1:0]  flags;
        result_t            expected_q [$];
        int                 mismatches;
        int                 checked;

        function new();
            process_var = PROCESS_VAR_RESET;
            meas_var    = MEASUREMENT_VAR_RESET;
            thr_front   = THRESHOLD_FRONT_RESET;
            thr_other   = THRESHOLD_OTHER_RESET;
            foreach (est_mem[i])
                est_mem[i] = '0;
            error_var  = ERROR_RESET;
            flags      = '0;
            mismatches = 0;
            checked    = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_PROCESS_VAR:     process_var = data;
                CFG_MEASUREMENT_VAR: meas_var    = data;
                CFG_THRESHOLD_FRONT: thr_front   = data;
                CFG_THRESHOLD_OTHER: thr_other   = data;
                default: ;
            endcase
        endfunction

        // one kalman update of the sample's channel, result queued
        function void note_sample(sample_t s);
            bit [63:0] prior;
            bit [63:0] den;
            bit [63:0] gain;
            bit [63:0] cur;
            bit [63:0] rng;
            bit [63:0] next_err;
            result_t   exp_r;
            prior = 64'(error_var) + 64'(process_var);
            if (prior > 64'h1FFFF)
                prior = 64'h1FFFF;
            den = prior + 64'(meas_var);
            gain = (den == 0) ? 64'd0 : (prior << 16) / den;
            if (gain > 64'hFFFF)
                gain = 64'hFFFF;
            cur = 64'(est_mem[s.channel]);
            rng = 64'(s.range_in);
            if (rng >= cur)
                cur = cur + ((gain * (rng - cur)) >> 16);
            else
                cur = cur - ((gain * (cur - rng)) >> 16);
            est_mem[s.channel] = cur[RANGE_W-1:0];
            next_err = ((64'h10000 - gain) * prior) >> 16;
            error_var = next_err[ERR_W-1:0];
            if (s.channel == 0)
                flags[0] = cur[RANGE_W-1:0] < thr_front;
            else
                flags[s.channel] = cur[RANGE_W-1:0] < thr_other;
            exp_r.channel_out = s.channel;
            exp_r.estimate    = cur[RANGE_W-1:0];
            exp_r.near_flags  = flags;
            expected_q = {expected_q, exp_r};
        endfunction

        function void report(string field, logic [15:0] want, logic [15:0] got);
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("mismatch in result %0d, %s: expected %h, got %h",
                         checked, field, want, got);
        endfunction

        function void check_result(result_t got);
            result_t exp_r;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("result with nothing expected: channel %0d estimate %h flags %b",
                             got.channel_out, got.estimate, got.near_flags);
                return;
            end
            exp_r = expected_q.pop_front();
            checked++;
            if (got.channel_out !== exp_r.channel_out)
                report("channel_out", 16'(exp_r.channel_out), 16'(got.channel_out));
            if (got.estimate !== exp_r.estimate)
                report("estimate", exp_r.estimate, got.estimate);
            if (got.near_flags !== exp_r.near_flags)
                report("near_flags", 16'(exp_r.near_flags), 16'(got.near_flags));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  sample_valid;
    logic                  sample_stall;
    sample_t               sample_in;
    logic                  result_valid;
    logic                  result_stall;
    result_t               result_out;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    kalman_scoreboard sb;
    int               sample_count;
    int               cfg_writes;
    bit               steady;
    bit               hold_done;

    range_kalman_proximity_flags DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample_in),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result_out),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int idle_cycles();
        int pick;
        if (steady)
            return 0;
        pick = int'($urandom_range(0, 99));
        if (pick < 60)
            return 0;
        if (pick < 88)
            return int'($urandom_range(1, 3));
        if (pick < 97)
            return int'($urandom_range(4, 12));
        return int'($urandom_range(20, 60));
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && sample_valid && !sample_stall)
        begin
            sb.note_sample(sample_in);
            sample_count++;
        end
        if (rst_n && result_valid && !result_stall)
            sb.check_result(result_out);
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((sample_valid && !sample_stall) || (result_valid && !result_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no transaction in %0d cycles", QUIET_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin : receiver
        int len;
        result_stall = 1'b0;
        hold_done    = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!hold_done && sample_count >= HOLD_AFTER)
            begin
                // long hold-off so the block backs up into its input
                result_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                result_stall = 1'b0;
                hold_done    = 1'b1;
            end
            else
            begin
                len = idle_cycles();
                result_stall = (len != 0);
                if (len > 1)
                    repeat (len - 1) @(negedge clk);
            end
        end
    end

    task automatic send_sample(input logic [CH_W-1:0] ch, input logic [RANGE_W-1:0] rng);
        int gap;
        sample_in.channel  = ch;
        sample_in.range_in = rng;
        sample_valid       = 1'b1;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        @(negedge clk);
        gap = idle_cycles();
        if (gap > 0)
        begin
            sample_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge clk);
        sb.set_reg(idx, data);
        cfg_writes++;
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    task automatic wait_idle();
        sample_valid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    task automatic load_config(input logic [15:0] pv, input logic [15:0] mv,
                               input logic [15:0] tf, input logic [15:0] to);
        wait_idle();
        write_cfg(CFG_PROCESS_VAR, pv);
        write_cfg(CFG_MEASUREMENT_VAR, mv);
        write_cfg(CFG_THRESHOLD_FRONT, tf);
        write_cfg(CFG_THRESHOLD_OTHER, to);
    endtask

    // mostly runs on one channel around a target so estimates settle and cross thresholds
    task automatic send_random(input int count);
        int              n;
        int              len;
        int              target;
        int              v;
        int              k;
        logic [CH_W-1:0] ch;
        n = 0;
        while (n < count)
        begin
            ch = CH_W'($urandom_range(0, 7));
            if ($urandom_range(0, 99) < 70)
            begin
                case ($urandom_range(0, 3))
                    0: target = int'((ch == 0) ? sb.thr_front : sb.thr_other)
                                + int'($urandom_range(0, 1024)) - 512;
                    1: target = int'($urandom_range(0, 65535));
                    2: target = ($urandom_range(0, 1) != 0) ? 65535 : 0;
                    default: target = int'($urandom_range(0, 16'h3000));
                endcase
                len = int'($urandom_range(2, 12));
                for (k = 0; k < len; k++)
                begin
                    v = target + int'($urandom_range(0, 256)) - 128;
                    if (v < 0)
                        v = 0;
                    else if (v > 65535)
                        v = 65535;
                    send_sample(ch, v[RANGE_W-1:0]);
                end
                n += len;
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0: v = 0;
                    1: v = 65535;
                    default: v = int'($urandom_range(0, 65535));
                endcase
                send_sample(ch, v[RANGE_W-1:0]);
                n++;
            end
        end
    endtask

    initial
    begin : main
        int p;
        sb           = new();
        rst_n        = 1'b0;
        sample_valid = 1'b0;
        sample_in    = '0;
        cfg_write    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        steady       = 1'b0;
        sample_count = 0;
        cfg_writes   = 0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // prior at its ceiling: reset error plus the largest process variance
        write_cfg(CFG_PROCESS_VAR, 16'hFFFF);
        send_sample(3'd0, 16'hFFFF);
        wait_idle();
        write_cfg(CFG_PROCESS_VAR, PROCESS_VAR_RESET);

        send_sample(3'd0, 16'h0000);
        send_sample(3'd1, 16'hFFFF);
        send_sample(3'd2, 16'h0800);
        send_sample(3'd3, 16'h0FFF);
        send_sample(3'd4, 16'hAAAA);
        send_sample(3'd5, 16'h5555);
        send_sample(3'd6, 16'h1000);
        send_sample(3'd7, 16'hFFFF);
        send_sample(3'd7, 16'h0000);
        send_sample(3'd0, 16'h0FFF);

        // both variances zero: gain saturates, then the prior collapses to zero
        wait_idle();
        write_cfg(CFG_PROCESS_VAR, 16'h0000);
        write_cfg(CFG_MEASUREMENT_VAR, 16'h0000);
        send_sample(3'd1, 16'h1234);
        send_sample(3'd2, 16'h0001);
        send_sample(3'd3, 16'h8000);
        send_sample(3'd4, 16'hFFFF);
        send_sample(3'd5, 16'h0000);

        load_config(16'hFFFF, 16'd1, 16'd0, 16'hFFFF);
        send_sample(3'd0, 16'h0000);
        send_sample(3'd6, 16'hFFFF);
        send_sample(3'd3, 16'h0000);

        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0: load_config(16'($urandom_range(0, 2000)), 16'($urandom_range(1, 20000)),
                               16'($urandom_range(16'h0400, 16'h2000)),
                               16'($urandom_range(16'h0400, 16'h2000)));
                1: load_config(16'hFFFF, 16'd1, 16'hFFFF, 16'd0);
                2: load_config(16'd0, 16'hFFFF, 16'($urandom_range(0, 65535)),
                               16'($urandom_range(0, 65535)));
                3: load_config(16'($urandom_range(0, 65535)), 16'($urandom_range(1, 65535)),
                               16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
                4: load_config(16'($urandom_range(0, 100)), 16'd0,
                               THRESHOLD_FRONT_RESET, THRESHOLD_OTHER_RESET);
                default: load_config(PROCESS_VAR_RESET, MEASUREMENT_VAR_RESET,
                                     THRESHOLD_FRONT_RESET, THRESHOLD_OTHER_RESET);
            endcase
            steady = (p == 3);
            send_random(PHASE_ITEMS);
            steady = 1'b0;
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("summary: %0d samples over %0d register settings, %0d results compared",
                 sample_count, RANDOM_PHASES + 4, sb.checked);
        $display("summary: %0d register writes, %0d mismatches, one %0d-cycle output hold-off",
                 cfg_writes, sb.mismatches, HOLD_CYCLES);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
